FILE: rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, codes, types and helpers of the unsigned string parser.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int unsigned MAX_STRING_BYTES = 65536;
    localparam int POS_W    = $clog2(MAX_STRING_BYTES + 1);
    localparam int COUNT_W  = 17;
    localparam int ACC_W    = 64;
    localparam int RADIX_W  = 6;
    localparam int DIGIT_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int PROD_W   = ACC_W + RADIX_W;
    localparam int TDATA_W  = ((ACC_W + COUNT_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_BYTES);

    localparam logic [PHASE_W-1:0] PHASE_SKIP   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DIGITS = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DRAIN  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_BIG   = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;

    localparam logic [BYTE_W-1:0] CHR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_LA   = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_LZ   = 8'h7A;
    localparam logic [BYTE_W-1:0] CHR_UA   = 8'h41;
    localparam logic [BYTE_W-1:0] CHR_UZ   = 8'h5A;
    localparam logic [BYTE_W-1:0] CHR_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CHR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] LETTER_OFS = 8'd10;

    typedef struct packed {
        logic               is_blank;
        logic               is_digit;
        logic [DIGIT_W-1:0] value;
    } t_char_class;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ACC_W-1:0]    value;
        logic [COUNT_W-1:0]  count;
    } t_result;

    function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] p);
        sat_next = (p >= POS_MAX) ? POS_MAX : p + POS_W'(1);
    endfunction

endpackage

FILE: rtl/scp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_cfg
// APB register slave holding the radix register.
// ----------------------------------------------------------------------------
module scp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scp_pkg::PADDR_W-1:0]   paddr,
    input  logic [scp_pkg::PDATA_W-1:0]   pwdata,
    output logic [scp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [scp_pkg::RADIX_W-1:0]   o_radix
);

    logic [scp_pkg::RADIX_W-1:0] r_radix;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready &&
                    (paddr[2] == scp_pkg::REG_RADIX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= scp_pkg::RADIX_RESET;
        end else if (wr_en) begin
            r_radix <= pwdata[scp_pkg::RADIX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            scp_pkg::REG_RADIX: prdata = scp_pkg::PDATA_W'(r_radix);
            default:            prdata = '0;
        endcase
    end

    assign o_radix = r_radix;

endmodule

FILE: rtl/scp_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_classify
// Character classifier: white space detect and digit value under the radix.
// ----------------------------------------------------------------------------
module scp_classify (
    input  logic [scp_pkg::BYTE_W-1:0]  i_byte,
    input  logic [scp_pkg::RADIX_W-1:0] i_radix,
    output scp_pkg::t_char_class        o_class
);

    logic [scp_pkg::BYTE_W-1:0]  v8;
    logic                        is_alnum;
    logic                        radix_ok;
    logic [scp_pkg::DIGIT_W-1:0] v6;

    always_comb begin
        v8       = '0;
        is_alnum = 1'b1;
        if (i_byte >= scp_pkg::CHR_0 && i_byte <= scp_pkg::CHR_9) begin
            v8 = i_byte - scp_pkg::CHR_0;
        end else if (i_byte >= scp_pkg::CHR_LA && i_byte <= scp_pkg::CHR_LZ) begin
            v8 = i_byte - scp_pkg::CHR_LA + scp_pkg::LETTER_OFS;
        end else if (i_byte >= scp_pkg::CHR_UA && i_byte <= scp_pkg::CHR_UZ) begin
            v8 = i_byte - scp_pkg::CHR_UA + scp_pkg::LETTER_OFS;
        end else begin
            is_alnum = 1'b0;
        end
    end

    assign v6       = v8[scp_pkg::DIGIT_W-1:0];
    assign radix_ok = (i_radix >= scp_pkg::RADIX_MIN) && (i_radix <= scp_pkg::RADIX_MAX);

    assign o_class.value    = v6;
    assign o_class.is_digit = is_alnum && radix_ok && (v6 < i_radix);
    assign o_class.is_blank = (i_byte == scp_pkg::CHR_SP) ||
                              (i_byte >= scp_pkg::CHR_TAB && i_byte <= scp_pkg::CHR_CR);

endmodule

FILE: rtl/scp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_step
// Parse state and per-step update: multiply-accumulate with overflow.
// ----------------------------------------------------------------------------
module scp_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [scp_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_last,
    input  logic [scp_pkg::RADIX_W-1:0] i_radix,
    output scp_pkg::t_result            o_result
);

    logic [scp_pkg::PHASE_W-1:0]  r_phase,  n_phase;
    logic [scp_pkg::ACC_W-1:0]    r_acc,    n_acc;
    logic [scp_pkg::POS_W-1:0]    r_pos,    n_pos;
    logic [scp_pkg::POS_W-1:0]    r_end,    n_end;
    logic [scp_pkg::STATUS_W-1:0] r_status, n_status;

    scp_pkg::t_char_class         cls;
    logic [scp_pkg::PHASE_W-1:0]  phase_eff;
    logic [scp_pkg::PROD_W-1:0]   wide;
    logic                         ovf;

    scp_classify u_classify (
        .i_byte  (i_byte),
        .i_radix (i_radix),
        .o_class (cls)
    );

    assign wide = scp_pkg::PROD_W'(r_acc) * scp_pkg::PROD_W'(i_radix)
                + scp_pkg::PROD_W'(cls.value);
    assign ovf  = |wide[scp_pkg::PROD_W-1:scp_pkg::ACC_W];

    always_comb begin
        n_acc    = r_acc;
        n_end    = r_end;
        n_status = r_status;
        n_pos    = scp_pkg::sat_next(r_pos);

        phase_eff = (r_phase == scp_pkg::PHASE_SKIP && !cls.is_blank) ?
                    scp_pkg::PHASE_DIGITS : r_phase;
        n_phase   = phase_eff;

        if (phase_eff == scp_pkg::PHASE_DIGITS) begin
            if (!cls.is_digit) begin
                n_phase = scp_pkg::PHASE_DRAIN;
            end else if (ovf) begin
                n_status = scp_pkg::STATUS_TOO_BIG;
                n_phase  = scp_pkg::PHASE_DRAIN;
            end else begin
                n_acc    = wide[scp_pkg::ACC_W-1:0];
                n_status = scp_pkg::STATUS_OK;
                n_end    = scp_pkg::sat_next(r_pos);
            end
        end else if (phase_eff != scp_pkg::PHASE_SKIP) begin
            n_phase = scp_pkg::PHASE_DRAIN;
        end
    end

    // result seen when the last byte is applied
    always_comb begin
        o_result.status = n_status;
        if (n_status == scp_pkg::STATUS_OK) begin
            o_result.value = n_acc;
            o_result.count = scp_pkg::COUNT_W'(n_end);
        end else begin
            o_result.value = '0;
            o_result.count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase  <= scp_pkg::PHASE_SKIP;
            r_acc    <= '0;
            r_pos    <= '0;
            r_end    <= '0;
            r_status <= scp_pkg::STATUS_NO_DIGITS;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_end    <= n_end;
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/string_to_unsigned_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_core
// Streaming unsigned integer parser, radix 2 to 36, with 64-bit overflow.
// ----------------------------------------------------------------------------
// Result path: a last-byte transaction is registered in the input stage, then
// its result in the output stage on o_m_tvalid. Throughput: 1 byte per cycle
// unless a full output stage stalls; the radix multiply-add is combinational.
// Reset: synchronous active low; clears parse state and both stages, radix
// returns to 10.
module string_to_unsigned_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [scp_pkg::BYTE_W-1:0]        i_s_tdata,  // [7:0] text_byte
    input  logic                              i_s_tlast,  // final_byte
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [scp_pkg::TDATA_W-1:0]       o_m_tdata,  // [63:0] parsed_value,
                                                          // [80:64] bytes_consumed
    output logic [scp_pkg::STATUS_W-1:0]      o_m_tuser,  // [1:0] parse_status
    // APB
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scp_pkg::PADDR_W-1:0]       paddr,
    input  logic [scp_pkg::PDATA_W-1:0]       pwdata,
    output logic [scp_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [scp_pkg::RADIX_W-1:0] radix;
    logic                        r_in_valid;
    logic [scp_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_in_last;
    logic                        r_out_valid;
    scp_pkg::t_result            r_out;
    scp_pkg::t_result            result;
    logic                        adv;
    logic                        s_xfer;

    scp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_radix (radix)
    );

    scp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_radix  (radix),
        .o_result (result)
    );

    // input stage moves on unless a result is blocked by a full output stage
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = scp_pkg::TDATA_W'({r_out.count, r_out.value});

endmodule
